// ===== hw/rtl/charging_limit_profile_table_macros.svh =====
// ----------------------------------------------------------------------------
// Charging limit profile table: assertion macros
// Concurrent assertion shorthands; they collapse to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef CHARGING_LIMIT_PROFILE_TABLE_MACROS_SVH
`define CHARGING_LIMIT_PROFILE_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define CLPT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define CLPT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CLPT_ASSERT(label, clk, rst_n, prop, msg)
`define CLPT_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== hw/rtl/clpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Charging limit profile table: shared package
// Field widths, command and purpose codes, request, entry and result types.
// ----------------------------------------------------------------------------
package clpt_pkg;

  localparam int unsigned CmdW         = 2;
  localparam int unsigned IdentW       = 32;
  localparam int unsigned ConnW        = 9;
  localparam int unsigned PurposeW     = 2;
  localparam int unsigned StackW       = 9;
  localparam int unsigned TxnW         = 32;
  localparam int unsigned LimitW       = 16;
  localparam int unsigned EntryConnW   = 8;
  localparam int unsigned EntryStackW  = 8;
  localparam int unsigned CountW       = 4;

  localparam int unsigned InDataW      = 104;
  localparam int unsigned InUserW      = CmdW;
  localparam int unsigned OutDataW     = 24;

  typedef logic [CmdW-1:0]     cmd_t;
  typedef logic [PurposeW-1:0] purpose_t;

  localparam cmd_t CMD_SET   = 2'd0;
  localparam cmd_t CMD_CLEAR = 2'd1;
  localparam cmd_t CMD_QUERY = 2'd2;

  localparam purpose_t PURPOSE_ANY        = 2'd0;
  localparam purpose_t PURPOSE_TX_PROFILE = 2'd3;

  typedef struct packed {
    cmd_t              cmd;
    logic [IdentW-1:0] ident;
    logic [ConnW-1:0]  conn;
    purpose_t          purpose;
    logic [StackW-1:0] stack;
    logic [TxnW-1:0]   txn;
    logic [LimitW-1:0] limit;
    logic              has_period;
  } req_t;

  typedef struct packed {
    logic [IdentW-1:0]      ident;
    logic [EntryConnW-1:0]  conn;
    purpose_t               purpose;
    logic [EntryStackW-1:0] stack;
    logic [TxnW-1:0]        txn;
    logic                   has_period;
    logic [LimitW-1:0]      limit;
  } entry_t;

  // Per-entry verdicts of the shared compare unit
  typedef struct packed {
    logic set_hit;
    logic set_free;
    logic clr_hit;
    logic qry_hit;
    logic qry_less;
  } cmp_t;

  typedef struct packed {
    logic              status;
    logic [CountW-1:0] cleared;
    logic              found;
    logic [LimitW-1:0] value;
  } res_t;

endpackage

// ===== hw/rtl/clpt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Charging limit profile table: generic RAM
// One write port, one read port with registered read data, no reset.
// ----------------------------------------------------------------------------
module clpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                        clk_i,
  input  logic                                        wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                            wr_data_i,
  input  logic                                        rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                            rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/clpt_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Charging limit profile table: shared compare unit
// Judge one table entry against the current command and the running minimum.
// ----------------------------------------------------------------------------
module clpt_cmp import clpt_pkg::*; (
  input  req_t              req_i,
  input  entry_t            entry_i,
  input  logic              valid_i,
  input  logic              best_found_i,
  input  logic [LimitW-1:0] best_i,
  output cmp_t              cmp_o
);

  logic ident_eq;
  logic clr_ident_ok;
  logic clr_conn_ok;
  logic clr_purpose_ok;
  logic clr_stack_ok;
  logic qry_conn_ok;
  logic qry_txn_ok;

  assign ident_eq = (entry_i.ident == req_i.ident);

  // Negative filter means any; connector and stack are stored as 8 bits
  assign clr_ident_ok   = req_i.ident[IdentW-1] | ident_eq;
  assign clr_conn_ok    = req_i.conn[ConnW-1]
                        | (entry_i.conn == req_i.conn[EntryConnW-1:0]);
  assign clr_purpose_ok = (req_i.purpose == PURPOSE_ANY) | (entry_i.purpose == req_i.purpose);
  assign clr_stack_ok   = req_i.stack[StackW-1]
                        | (entry_i.stack == req_i.stack[EntryStackW-1:0]);

  // Connector 0 applies everywhere; a negative query connector never matches
  assign qry_conn_ok = (entry_i.conn == '0) | ({1'b0, entry_i.conn} == req_i.conn);
  assign qry_txn_ok  = (entry_i.purpose != PURPOSE_TX_PROFILE) | (entry_i.txn == req_i.txn);

  always_comb begin
    cmp_o          = '0;
    cmp_o.set_hit  = valid_i & ident_eq;
    cmp_o.set_free = ~valid_i;
    cmp_o.clr_hit  = valid_i & clr_ident_ok & clr_conn_ok & clr_purpose_ok & clr_stack_ok;
    cmp_o.qry_hit  = valid_i & qry_conn_ok & qry_txn_ok & entry_i.has_period;
    cmp_o.qry_less = ~best_found_i | (entry_i.limit < best_i);
  end

endmodule

// ===== hw/rtl/clpt_seq.sv =====
`timescale 1ns / 1ps
`include "charging_limit_profile_table_macros.svh"
// ----------------------------------------------------------------------------
// Charging limit profile table: scan sequencer
// Walk the entry RAM one entry a cycle through the compare unit, then commit.
// ----------------------------------------------------------------------------
module clpt_seq import clpt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic ready_o,
  input  logic res_take_i,
  output logic res_vld_o,
  output res_t res_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);
  localparam int unsigned EntW = $bits(entry_t);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_FINISH = 5'b01000,
    ST_HAND   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              eval_vld_q, eval_vld_d;
  logic [IdxW-1:0]   eval_idx_q;
  req_t              req_q;
  logic              valid_q [TABLE_ENTRIES];
  logic              hit_found_q;
  logic [IdxW-1:0]   hit_idx_q;
  logic              free_found_q;
  logic [IdxW-1:0]   free_idx_q;
  logic [CountW-1:0] cleared_q;
  logic              best_found_q;
  logic [LimitW-1:0] best_q;
  res_t              res_q;

  logic              accept;
  logic              rd_en;
  logic [EntW-1:0]   rd_data;
  entry_t            rd_entry;
  cmp_t              cmp;
  logic              ram_wr_en;
  logic [IdxW-1:0]   wr_idx;
  entry_t            wr_entry;

  function automatic entry_t make_entry(req_t r);
    entry_t e;
    e.ident      = r.ident;
    e.conn       = r.conn[EntryConnW-1:0];
    e.purpose    = r.purpose;
    e.stack      = r.stack[StackW-1] ? '0 : r.stack[EntryStackW-1:0];
    e.txn        = r.txn;
    e.has_period = r.has_period;
    e.limit      = r.has_period ? r.limit : '0;
    return e;
  endfunction

  assign accept    = start_i && (state_q == ST_IDLE);
  assign rd_en     = (state_q == ST_SCAN);
  assign rd_entry  = entry_t'(rd_data);
  assign wr_idx    = hit_found_q ? hit_idx_q : free_idx_q;
  assign wr_entry  = make_entry(req_q);
  assign ram_wr_en = (state_q == ST_FINISH) && (req_q.cmd == CMD_SET)
                   && (hit_found_q || free_found_q);

  clpt_ram #(
    .WIDTH (EntW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (wr_idx),
    .wr_data_i (EntW'(wr_entry)),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  clpt_cmp u_cmp (
    .req_i        (req_q),
    .entry_i      (rd_entry),
    .valid_i      (valid_q[eval_idx_q]),
    .best_found_i (best_found_q),
    .best_i       (best_q),
    .cmp_o        (cmp)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    eval_vld_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (start_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        eval_vld_d = 1'b1;
        if (idx_q == LastIdx) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN:  state_d = ST_FINISH;
      ST_FINISH: state_d = ST_HAND;
      ST_HAND: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      eval_vld_q   <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      state_q    <= state_d;
      eval_vld_q <= eval_vld_d;
      if (accept) begin
        hit_found_q  <= 1'b0;
        free_found_q <= 1'b0;
        best_found_q <= 1'b0;
      end else if (eval_vld_q) begin
        if (req_q.cmd == CMD_SET) begin
          if (cmp.set_hit) hit_found_q <= 1'b1;
          if (cmp.set_free) free_found_q <= 1'b1;
        end
        if (req_q.cmd == CMD_CLEAR && cmp.clr_hit) begin
          valid_q[eval_idx_q] <= 1'b0;
        end
        if (req_q.cmd == CMD_QUERY && cmp.qry_hit) begin
          best_found_q <= 1'b1;
        end
      end
      if (ram_wr_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
    end
  end

  // Payload: request, scan accumulators and result
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    eval_idx_q <= idx_q;
    if (accept) begin
      req_q     <= req_i;
      cleared_q <= '0;
      best_q    <= '0;
    end else if (eval_vld_q) begin
      // keep the lowest-numbered hit and free entry
      if (req_q.cmd == CMD_SET && cmp.set_hit && !hit_found_q) begin
        hit_idx_q <= eval_idx_q;
      end
      if (req_q.cmd == CMD_SET && cmp.set_free && !free_found_q) begin
        free_idx_q <= eval_idx_q;
      end
      if (req_q.cmd == CMD_CLEAR && cmp.clr_hit && (cleared_q != '1)) begin
        cleared_q <= cleared_q + 1'b1;
      end
      if (req_q.cmd == CMD_QUERY && cmp.qry_hit && cmp.qry_less) begin
        best_q <= rd_entry.limit;
      end
    end
    if (state_q == ST_FINISH) begin
      res_q.status  <= (req_q.cmd == CMD_SET) && !hit_found_q && !free_found_q;
      res_q.cleared <= (req_q.cmd == CMD_CLEAR) ? cleared_q : '0;
      res_q.found   <= (req_q.cmd == CMD_QUERY) && best_found_q;
      res_q.value   <= ((req_q.cmd == CMD_QUERY) && best_found_q) ? best_q : '0;
    end
  end

  assign ready_o   = (state_q == ST_IDLE);
  assign res_vld_o = (state_q == ST_HAND);
  assign res_o     = res_q;

  `CLPT_ASSERT(a_eval_in_scan, clk_i, rst_ni, eval_vld_q |-> (state_q == ST_SCAN || state_q == ST_DRAIN), "entry evaluated outside the scan")
  `CLPT_ASSERT(a_write_on_set, clk_i, rst_ni, ram_wr_en |-> (state_q == ST_FINISH && req_q.cmd == CMD_SET), "entry RAM written outside a set commit")
  `CLPT_ASSERT(a_finish_to_hand, clk_i, rst_ni, (state_q == ST_FINISH) |=> (state_q == ST_HAND), "result not offered after commit")
  `CLPT_ASSERT(a_start_scans, clk_i, rst_ni, accept |=> (state_q == ST_SCAN && idx_q == '0), "accepted command did not start scan at entry zero")
  `CLPT_ASSERT_NEVER(a_no_start_busy, clk_i, rst_ni, start_i && (state_q != ST_IDLE), "command started while busy")

endmodule

// ===== hw/rtl/charging_limit_profile_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Charging limit profile table
// Command-driven table of charging-limit profiles: set, clear and query.
// ----------------------------------------------------------------------------
// Each command arrives as one transfer on the slave stream and yields exactly
// one result transfer on the master stream. The block scans its table one
// entry per cycle: an entry RAM with registered read feeds a single compare
// unit under a small sequencer, which steps through its scan, drain, finish
// and hand-off states; in hand-off it waits until the output register can take
// the result, and then loads it there. The scan length is set by the one
// RAM read port and the one compare unit. While a command is in progress the
// slave tready stays low; it rises again as soon as the result has moved into
// the output register, even if the downstream side has not yet taken it.
// Set overwrites the valid entry with the same profile id, else fills the
// lowest free entry, else reports status 1 and changes nothing. Clear drops
// every valid entry matching all filters (negative id, connector or stack
// level and purpose 0 mean any) and returns the count, saturating at 15.
// Query returns the smallest first-period limit (tenths of an ampere) among
// valid entries with a period whose connector is 0 or the one asked for; a
// TxProfile entry must also carry the asked transaction. Command code 3 does
// nothing and returns all zeros. Valid bits clear at reset; entry contents
// need no clearing since they are read only behind a valid bit.
// ----------------------------------------------------------------------------
module charging_limit_profile_table import clpt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // profile_ident[31:0], connector[40:32], purpose_code[42:41], stack_lvl[51:43],
  // transaction[83:52], first_limit[99:84], has_period[100], zero pad[103:101]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // command[1:0]
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // status[0], cleared_count[4:1], limit_found[5], limit_value[21:6], zero pad[23:22]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  req_t                req;
  logic                seq_ready;
  logic                start;
  logic                res_vld;
  res_t                res;
  logic                out_free;
  logic                m_tvalid_q;
  logic [OutDataW-1:0] m_tdata_q;

  // Unpack the command transfer
  always_comb begin
    req            = '0;
    req.cmd        = s_axis_tuser_i[CmdW-1:0];
    req.ident      = s_axis_tdata_i[31:0];
    req.conn       = s_axis_tdata_i[40:32];
    req.purpose    = s_axis_tdata_i[42:41];
    req.stack      = s_axis_tdata_i[51:43];
    req.txn        = s_axis_tdata_i[83:52];
    req.limit      = s_axis_tdata_i[99:84];
    req.has_period = s_axis_tdata_i[100];
  end

  assign s_axis_tready_o = seq_ready;
  assign start           = s_axis_tvalid_i && seq_ready;

  clpt_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (req),
    .ready_o    (seq_ready),
    .res_take_i (out_free),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  // Output register: take a new result whenever the held one is gone or leaving
  assign out_free = !m_tvalid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (res_vld && out_free) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  // Hold the payload until the downstream side takes the transfer
  always_ff @(posedge clk_i) begin
    if (res_vld && out_free) begin
      m_tdata_q <= {2'b00, res.value, res.found, res.cleared, res.status};
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

endmodule
